@@ sv/rsmf_pkg.sv @@
`timescale 1ns / 1ps
// rsmf_pkg: shared constants, codes and types of the ring slot message framer
// no dependencies; imported by the framer unit, rsmf_front, rsmf_queue and rsmf_back

package rsmf_pkg;

    localparam int RING_SLOTS = 32;
    localparam int SLOT_W     = $clog2(RING_SLOTS);
    // wide enough to hold both the 5-bit freed slot field and RING_SLOTS
    localparam int FREE_W     = ((SLOT_W > 5) ? SLOT_W : 5) + 1;

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [4:0] FLAG_WAITING = 5'd1;
    localparam logic [4:0] FLAG_BEGIN   = 5'd2;
    localparam logic [4:0] FLAG_END     = 5'd4;
    localparam logic [4:0] FLAG_SIZE32  = 5'd8;
    localparam logic [4:0] FLAG_SIZE64  = 5'd16;

    localparam logic [5:0] LAST_OFFSET = 6'd63;

    // one queued job: the writes and status that one input transaction produces
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        status;
        logic [3:0]        data_cnt;
        logic [3:0]        nsize;
        logic [5:0]        base_off;
        logic [62:0]       size;
        logic [7:0]        byte_a;
        logic [7:0]        byte_b;
        logic              close;
        logic [7:0]        flag_val;
        logic              done;
    } t_job;

    function automatic logic [4:0] to_slot5(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+4:0] w;
        w = {{5{1'b0}}, s};
        return w[4:0];
    endfunction

endpackage

@@ sv/rsmf_in_if.sv @@
`timescale 1ns / 1ps
// rsmf_in_if: input channel of the framer, valid/ready plus the item fields
// depends on nothing

interface rsmf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  msg_type;
    logic [7:0]  msg_id;
    logic [62:0] msg_size;
    logic [7:0]  payload_byte;
    logic [4:0]  freed_slot;

    modport source (
        output valid, operation, msg_type, msg_id, msg_size, payload_byte, freed_slot,
        input  ready
    );
    modport sink (
        input  valid, operation, msg_type, msg_id, msg_size, payload_byte, freed_slot,
        output ready
    );
endinterface

@@ sv/rsmf_out_if.sv @@
`timescale 1ns / 1ps
// rsmf_out_if: result channel of the framer, valid/ready plus the result fields
// depends on nothing

interface rsmf_out_if;
    logic       valid;
    logic       ready;
    logic       write_valid;
    logic [4:0] slot;
    logic [5:0] offset;
    logic [7:0] byte_value;
    logic [1:0] status;
    logic       message_done;
    logic       last;

    modport source (
        output valid, write_valid, slot, offset, byte_value, status, message_done, last,
        input  ready
    );
    modport sink (
        input  valid, write_valid, slot, offset, byte_value, status, message_done, last,
        output ready
    );
endinterface

@@ sv/ring_slot_message_framer_unit.sv @@
`timescale 1ns / 1ps
// Ring slot message framer: cuts messages into 64-byte ring slots and emits
// byte writes for headers, payload and slot flag bytes.
// Input channel i_in: one transaction per start, payload byte or slot release.
// Output channel o_out: one transaction per byte write into the ring, or one
// status-only transaction for items that write nothing; last marks the final
// result of each input transaction.
// The first result of an item passes through the job queue and then the
// registered output stage before it is presented on o_out.
// Throughput: one input item per cycle while the queue is not full. Results
// leave at one per cycle while o_out.ready is high: a payload byte gives one,
// or two when it closes a slot; a start gives 2 to 10, or 1 when rejected.
// The front part updates all framing state at acceptance and queues one job
// per item in a 4-entry queue; i_in.ready drops only while that queue is full.
// Receiver stall: o_out holds its result while o_out.ready is low; the queue
// absorbs following items until it fills.
// Reset (synchronous, active low): ring empty, no message open, queue and
// output stage empty.
// Depends on rsmf_pkg, rsmf_in_if, rsmf_out_if, rsmf_front, rsmf_queue, rsmf_back.

module ring_slot_message_framer_unit import rsmf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsmf_in_if.sink     i_in,
    rsmf_out_if.source  o_out
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job front_job;
    t_job head_job;

    rsmf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    rsmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    rsmf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

@@ sv/rsmf_front.sv @@
`timescale 1ns / 1ps
// rsmf_front: accepts input transactions, keeps the framing state and ring
// busy bits, and turns each transaction into one job; uses rsmf_pkg, rsmf_in_if

module rsmf_front import rsmf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsmf_in_if.sink      i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_job         o_job
);

    logic [SLOT_W-1:0]     r_next_slot, n_next_slot;
    logic [RING_SLOTS-1:0] r_busy, n_busy;
    logic                  r_in_msg, n_in_msg;
    logic [62:0]           r_rem, n_rem;       // bytes still to send
    logic                  r_slot_open, n_slot_open;
    logic [5:0]            r_fill, n_fill;
    logic [5:0]            r_end, n_end;
    logic [4:0]            r_flags, n_flags;

    logic              accept;
    logic              busy_cur;
    logic [SLOT_W-1:0] slot_adv;
    logic              short_msg, big;
    logic [3:0]        nsize;
    logic [4:0]        sflags;
    logic [5:0]        hoff;
    logic [5:0]        pf, pe;
    logic [4:0]        pfl;
    logic              pclose;
    logic [FREE_W-1:0] free_ext;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept;
    assign busy_cur   = r_busy[r_next_slot];
    assign slot_adv   = (r_next_slot == SLOT_W'(RING_SLOTS - 1)) ? '0
                                                                  : r_next_slot + 1'b1;
    assign free_ext   = FREE_W'(i_in.freed_slot);

    // start header layout
    assign short_msg = (i_in.msg_size <= 63'd61);
    assign big       = |i_in.msg_size[62:32];
    assign nsize     = short_msg ? 4'd0 : (big ? 4'd8 : 4'd4);
    assign sflags    = FLAG_BEGIN | (short_msg ? FLAG_END : 5'd0)
                     | ((!short_msg && !big) ? FLAG_SIZE32 : 5'd0)
                     | (big ? FLAG_SIZE64 : 5'd0);
    assign hoff      = 6'(nsize) + 6'd3;

    // payload slot view, opening a fresh slot when none is open
    always_comb begin
        if (r_slot_open) begin
            pf  = r_fill;
            pe  = r_end;
            pfl = r_flags;
        end else begin
            pf = 6'd1;
            if (r_rem[62:6] == '0) begin
                pe  = r_rem[5:0];
                pfl = FLAG_END;
            end else begin
                pe  = LAST_OFFSET;
                pfl = 5'd0;
            end
        end
        pclose = (pf >= pe);
    end

    always_comb begin
        n_next_slot = r_next_slot;
        n_busy      = r_busy;
        n_in_msg    = r_in_msg;
        n_rem       = r_rem;
        n_slot_open = r_slot_open;
        n_fill      = r_fill;
        n_end       = r_end;
        n_flags     = r_flags;

        o_job          = '0;
        o_job.slot     = r_next_slot;
        o_job.status   = ST_OK;
        o_job.size     = i_in.msg_size;
        o_job.byte_a   = i_in.payload_byte;

        case (i_in.operation)
            OP_START: begin
                if (r_in_msg) begin
                    o_job.status = ST_BAD;
                end else if (busy_cur) begin
                    o_job.status = ST_FULL;
                end else begin
                    n_in_msg       = 1'b1;
                    n_rem          = i_in.msg_size;
                    n_slot_open    = 1'b1;
                    n_flags        = sflags;
                    n_fill         = hoff;
                    o_job.data_cnt = nsize + 4'd2;
                    o_job.nsize    = nsize;
                    o_job.base_off = 6'd1;
                    o_job.byte_a   = i_in.msg_type;
                    o_job.byte_b   = i_in.msg_id;
                    o_job.flag_val = {3'b000, sflags | FLAG_WAITING};
                    o_job.done     = 1'b1;
                    if (short_msg) begin
                        if (i_in.msg_size == '0) begin
                            // empty message closes its only slot right away
                            n_end                = hoff;
                            n_busy[r_next_slot]  = 1'b1;
                            n_next_slot          = slot_adv;
                            n_slot_open          = 1'b0;
                            n_in_msg             = 1'b0;
                            o_job.close          = 1'b1;
                        end else begin
                            n_end = 6'd2 + i_in.msg_size[5:0];
                        end
                    end else begin
                        n_end = LAST_OFFSET;
                    end
                end
            end
            OP_PAYLOAD: begin
                if (!r_in_msg) begin
                    o_job.status = ST_BAD;
                end else if (!r_slot_open && busy_cur) begin
                    o_job.status = ST_FULL;
                end else begin
                    n_end          = pe;
                    n_flags        = pfl;
                    n_rem          = r_rem - 63'd1;
                    o_job.data_cnt = 4'd1;
                    o_job.base_off = pf;
                    o_job.close    = pclose;
                    o_job.flag_val = {3'b000, pfl | FLAG_WAITING};
                    o_job.done     = (r_rem[62:1] == '0);
                    if (pclose) begin
                        n_fill              = pf;
                        n_busy[r_next_slot] = 1'b1;
                        n_next_slot         = slot_adv;
                        n_slot_open         = 1'b0;
                        if (r_rem[62:1] == '0) begin
                            n_in_msg = 1'b0;
                        end
                    end else begin
                        n_slot_open = 1'b1;
                        n_fill      = pf + 6'd1;
                    end
                end
            end
            OP_RELEASE: begin
                if (free_ext < FREE_W'(RING_SLOTS)) begin
                    n_busy[free_ext[SLOT_W-1:0]] = 1'b0;
                end else begin
                    o_job.status = ST_BAD;
                end
            end
            default: begin
                o_job.status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= '0;
            r_busy      <= '0;
            r_in_msg    <= 1'b0;
            r_rem       <= '0;
            r_slot_open <= 1'b0;
            r_fill      <= '0;
            r_end       <= '0;
            r_flags     <= '0;
        end else if (accept) begin
            r_next_slot <= n_next_slot;
            r_busy      <= n_busy;
            r_in_msg    <= n_in_msg;
            r_rem       <= n_rem;
            r_slot_open <= n_slot_open;
            r_fill      <= n_fill;
            r_end       <= n_end;
            r_flags     <= n_flags;
        end
    end

endmodule

@@ sv/rsmf_queue.sv @@
`timescale 1ns / 1ps
// rsmf_queue: short job queue between the front and the back part
// uses rsmf_pkg for the job type and depth

module rsmf_queue import rsmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("job popped from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("queue fill count out of range");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count missed a push");

endmodule

@@ sv/rsmf_back.sv @@
`timescale 1ns / 1ps
// rsmf_back: expands queued jobs into result transactions, one per cycle while
// o_out.ready is high, into a registered output stage; uses rsmf_pkg, rsmf_out_if

module rsmf_back import rsmf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    rsmf_out_if.source  o_out
);

    logic [3:0]  r_step;
    logic        r_valid;
    logic        r_write_valid;
    logic [4:0]  r_slot;
    logic [5:0]  r_offset;
    logic [7:0]  r_byte;
    logic [1:0]  r_status;
    logic        r_done;
    logic        r_last;

    logic [3:0]  total;
    logic        step_last;
    logic        advance;
    logic [63:0] size64;
    logic        n_write_valid;
    logic [5:0]  n_offset;
    logic [7:0]  n_byte;
    logic        n_done;

    assign total     = i_job.data_cnt + {3'b000, i_job.close};
    assign step_last = (total == 4'd0) || (r_step == total - 4'd1);
    assign advance   = i_valid && (!r_valid || o_out.ready);
    assign o_pop     = advance && step_last;
    assign size64    = {1'b0, i_job.size};

    always_comb begin
        n_write_valid = 1'b0;
        n_offset      = 6'd0;
        n_byte        = 8'd0;
        n_done        = 1'b0;
        if (total != 4'd0) begin
            n_write_valid = 1'b1;
            if (r_step < i_job.data_cnt) begin
                n_offset = i_job.base_off + {2'b00, r_step};
                if (r_step < i_job.nsize) begin
                    // little-endian size bytes
                    n_byte = size64[{r_step[2:0], 3'b000} +: 8];
                end else if (r_step == i_job.nsize) begin
                    n_byte = i_job.byte_a;
                end else begin
                    n_byte = i_job.byte_b;
                end
            end else begin
                // flag byte that closes the slot
                n_byte = i_job.flag_val;
                n_done = i_job.done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
            r_step  <= step_last ? 4'd0 : r_step + 4'd1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_write_valid <= n_write_valid;
            r_slot        <= to_slot5(i_job.slot);
            r_offset      <= n_offset;
            r_byte        <= n_byte;
            r_status      <= i_job.status;
            r_done        <= n_done;
            r_last        <= step_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.write_valid  = r_write_valid;
    assign o_out.slot         = r_slot;
    assign o_out.offset       = r_offset;
    assign o_out.byte_value   = r_byte;
    assign o_out.status       = r_status;
    assign o_out.message_done = r_done;
    assign o_out.last         = r_last;

endmodule
